### design/lup_decomposition_core_defines.svh
// assertion macros used by the checker file
`ifndef LUP_DECOMPOSITION_CORE_DEFINES_SVH
`define LUP_DECOMPOSITION_CORE_DEFINES_SVH

// same-cycle implication
`define LUPD_ASSERT_IMPL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("lupd assertion failed");

// next-cycle implication
`define LUPD_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lupd assertion failed");

`endif

### design/lupd_pkg.sv
package lupd_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SIZE_W     = 3;
   localparam int THR_W      = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_SIZE     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PIVOT_THRESHOLD = 8'd1;

   typedef enum logic [4:0] {
      S_LOAD,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_PIVOT,
      S_DEGEN_WAIT,
      S_ELIM_RD,
      S_DIV_LD,
      S_DIV,
      S_DIV_WR,
      S_UPD_RDU,
      S_UPD_MUL,
      S_UPD_WR,
      S_DET_RD,
      S_DET_MUL,
      S_DET_ACC,
      S_DET_SIGN,
      S_OUT_RD,
      S_OUT_LD,
      S_OUT_WAIT
   } state_type;

endpackage

### design/lup_decomposition_core.sv
// LU decomposition with partial pivoting on a square matrix of signed Q16.16 elements.
// Elements arrive one word per cycle in row-major order and go straight into a
// single-port-read / single-port-write matrix RAM; input is held off while a
// factorization runs or its results drain. The factor runs in place on that
// RAM: row swaps only permute a small row map, so source_row is read from it
// directly. For column j the pivot search reads rows j to n-1, then one
// decision state checks the pivot and swaps the row map. For each row below
// the pivot a bit-serial restoring divider forms the multiplier, then each
// element right of column j is updated by one RAM read for the pivot row, one
// multiply and one RAM read-modify-write. The determinant is then formed over
// the U diagonal, and the n*n results are sent one by one, each held through
// any rsp stall.
// A pivot below pivot_threshold, or zero, ends the run early with one degenerate
// word. csr writes are taken at any time, but only while idle do they have a
// defined effect; writing matrix_size restarts a partial load.
module lup_decomposition_core
   import lupd_pkg::*;
#(
   parameter int MAX_SIZE      = 4,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // element_value
   input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]          req_tdata,

   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // out_row, out_col, lu_value, source_row, determinant, odd_swaps
   output logic [((3*$clog2(MAX_SIZE)+2*ELEMENT_WIDTH+1+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic [0:0]                                 rsp_tuser,
   output logic                                       rsp_tlast,

   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [CSR_IDX_W-1:0]                       csr_index,
   input  logic [CSR_DATA_W-1:0]                      csr_data
);

   localparam int IW    = $clog2(MAX_SIZE);
   localparam int CW    = $clog2(MAX_SIZE + 1);
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = ELEMENT_WIDTH;
   localparam int NW    = EW + FRAC_BITS;
   localparam int QCW   = $clog2(NW + 1);
   localparam int RSP_W = ((3*IW + 2*EW + 1 + 7) / 8) * 8;

   localparam logic [EW-1:0] EMAX  = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] EMIN  = {1'b1, {(EW-1){1'b0}}};
   localparam logic [EW-1:0] Q_ONE = EW'(1) << FRAC_BITS;

   // ---------------------------------------------------------------- helpers
   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
      addr_of = AW'(r) * AW'(MAX_SIZE) + AW'(c);
   endfunction

   function automatic logic [EW-1:0] mag_of(input logic [EW-1:0] v);
      mag_of = v[EW-1] ? (~v + EW'(1)) : v;
   endfunction

   // floor(p / 2^16), saturated
   function automatic logic [EW-1:0] sat_prod(input logic signed [2*EW-1:0] p);
      logic signed [2*EW-1:0] s;
      s = p >>> FRAC_BITS;
      if ((&s[2*EW-1:EW-1]) || !(|s[2*EW-1:EW-1])) begin
         sat_prod = s[EW-1:0];
      end else begin
         sat_prod = s[2*EW-1] ? EMIN : EMAX;
      end
   endfunction

   function automatic logic [EW-1:0] sat_sub(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic [EW:0] d;
      d = {a[EW-1], a} - {b[EW-1], b};
      if (d[EW] == d[EW-1]) begin
         sat_sub = d[EW-1:0];
      end else begin
         sat_sub = d[EW] ? EMIN : EMAX;
      end
   endfunction

   // ---------------------------------------------------------------- state
   state_type st_ff, st_in;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [IW-1:0]     ld_row_ff, ld_row_in, ld_col_ff, ld_col_in;

   logic [CW-1:0]     j_ff, j_in, i_ff, i_in, c_ff, c_in;
   logic [IW-1:0]     best_ff, best_in;
   logic [EW-1:0]     best_mag_ff, best_mag_in;
   logic [EW-1:0]     pivot_ff, pivot_in;
   logic [EW-1:0]     mult_ff, mult_in;
   logic [2*EW-1:0]   prod_ff, prod_in;
   logic [EW-1:0]     det_ff, det_in;
   logic              parity_ff, parity_in;
   logic [IW-1:0]     perm_ff [MAX_SIZE];
   logic [IW-1:0]     perm_in [MAX_SIZE];

   // bit-serial divider
   logic [NW-1:0]     dnum_ff, dnum_in, dquo_ff, dquo_in;
   logic [EW-1:0]     drem_ff, drem_in, dden_ff, dden_in;
   logic [QCW-1:0]    dcnt_ff, dcnt_in;
   logic              dneg_ff, dneg_in;

   // output word register
   logic              o_valid_ff, o_valid_in;
   logic [IW-1:0]     o_row_ff, o_row_in, o_col_ff, o_col_in, o_src_ff, o_src_in;
   logic [EW-1:0]     o_val_ff, o_val_in, o_det_ff, o_det_in;
   logic              o_odd_ff, o_odd_in, o_degen_ff, o_degen_in, o_last_ff, o_last_in;

   // matrix ram
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [EW-1:0]     ram_wdata, ram_rdata;

   lupd_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- datapath terms
   logic [CW-1:0]   n_use, n_m1;
   logic [IW-1:0]   ji, ii, ci, pj, pi;
   logic [EW-1:0]   rd_mag;
   logic [EW:0]     dtrial;
   logic [EW-1:0]   mul_a;
   logic [EW-1:0]   div_res;
   logic            last_load, out_last;

   always_comb begin
      if (size_ff == '0) begin
         n_use = CW'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         n_use = CW'(MAX_SIZE);
      end else begin
         n_use = CW'(size_ff);
      end
   end

   assign n_m1      = n_use - CW'(1);
   assign ji        = j_ff[IW-1:0];
   assign ii        = i_ff[IW-1:0];
   assign ci        = c_ff[IW-1:0];
   assign pj        = perm_ff[ji];
   assign pi        = perm_ff[ii];
   assign rd_mag    = mag_of(ram_rdata);
   assign dtrial    = {drem_ff, dnum_ff[NW-1]};
   assign mul_a     = (st_ff == S_DET_MUL) ? det_ff : mult_ff;
   assign last_load = (CW'(ld_row_ff) == n_m1) && (CW'(ld_col_ff) == n_m1);
   assign out_last  = (i_ff == n_m1) && (c_ff == n_m1);

   // signed quotient with saturation
   always_comb begin
      if (!dneg_ff) begin
         div_res = (|dquo_ff[NW-1:EW-1]) ? EMAX : dquo_ff[EW-1:0];
      end else if ((|dquo_ff[NW-1:EW]) || (dquo_ff[EW-1] && (|dquo_ff[EW-2:0]))) begin
         div_res = EMIN;
      end else begin
         div_res = ~dquo_ff[EW-1:0] + EW'(1);
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      st_in       = st_ff;
      size_in     = size_ff;
      thr_in      = thr_ff;
      ld_row_in   = ld_row_ff;
      ld_col_in   = ld_col_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      c_in        = c_ff;
      best_in     = best_ff;
      best_mag_in = best_mag_ff;
      pivot_in    = pivot_ff;
      mult_in     = mult_ff;
      prod_in     = prod_ff;
      det_in      = det_ff;
      parity_in   = parity_ff;
      perm_in     = perm_ff;
      dnum_in     = dnum_ff;
      dquo_in     = dquo_ff;
      drem_in     = drem_ff;
      dden_in     = dden_ff;
      dcnt_in     = dcnt_ff;
      dneg_in     = dneg_ff;
      o_valid_in  = o_valid_ff;
      o_row_in    = o_row_ff;
      o_col_in    = o_col_ff;
      o_src_in    = o_src_ff;
      o_val_in    = o_val_ff;
      o_det_in    = o_det_ff;
      o_odd_in    = o_odd_ff;
      o_degen_in  = o_degen_ff;
      o_last_in   = o_last_ff;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_raddr   = '0;
      req_tready  = 1'b0;

      // word taken downstream
      if (o_valid_ff && rsp_tready) begin
         o_valid_in = 1'b0;
      end

      case (st_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ram_we    = 1'b1;
               ram_waddr = addr_of(ld_row_ff, ld_col_ff);
               ram_wdata = req_tdata[EW-1:0];
               if (CW'(ld_col_ff) == n_m1) begin
                  ld_col_in = '0;
                  ld_row_in = ld_row_ff + IW'(1);
               end else begin
                  ld_col_in = ld_col_ff + IW'(1);
               end
               if (last_load) begin
                  ld_row_in = '0;
                  ld_col_in = '0;
                  for (int k = 0; k < MAX_SIZE; k++) begin
                     perm_in[k] = IW'(k);
                  end
                  parity_in   = 1'b0;
                  j_in        = '0;
                  i_in        = '0;
                  best_in     = '0;
                  best_mag_in = '0;
                  st_in       = S_SRCH_RD;
               end
            end
         end

         // pivot search down column j
         S_SRCH_RD: begin
            ram_raddr = addr_of(pi, ji);
            st_in     = S_SRCH_CMP;
         end

         S_SRCH_CMP: begin
            if (rd_mag > best_mag_ff) begin
               best_mag_in = rd_mag;
               best_in     = ii;
               pivot_in    = ram_rdata;
            end
            i_in = i_ff + CW'(1);
            if (i_ff == n_m1) begin
               st_in = S_PIVOT;
            end else begin
               st_in = S_SRCH_RD;
            end
         end

         S_PIVOT: begin
            if (best_mag_ff == '0 || best_mag_ff < EW'(thr_ff)) begin
               o_valid_in = 1'b1;
               o_row_in   = ji;
               o_col_in   = ji;
               o_src_in   = '0;
               o_val_in   = '0;
               o_det_in   = '0;
               o_odd_in   = 1'b0;
               o_degen_in = 1'b1;
               o_last_in  = 1'b1;
               st_in      = S_DEGEN_WAIT;
            end else begin
               perm_in[ji]      = perm_ff[best_ff];
               perm_in[best_ff] = perm_ff[ji];
               if (best_ff != ji) begin
                  parity_in = ~parity_ff;
               end
               if (j_ff == n_m1) begin
                  i_in   = '0;
                  det_in = Q_ONE;
                  st_in  = S_DET_RD;
               end else begin
                  i_in  = j_ff + CW'(1);
                  st_in = S_ELIM_RD;
               end
            end
         end

         S_DEGEN_WAIT: begin
            if (rsp_tready) begin
               st_in = S_LOAD;
            end
         end

         // multiplier for row i
         S_ELIM_RD: begin
            ram_raddr = addr_of(pi, ji);
            st_in     = S_DIV_LD;
         end

         S_DIV_LD: begin
            dneg_in = ram_rdata[EW-1] ^ pivot_ff[EW-1];
            dnum_in = {rd_mag, {FRAC_BITS{1'b0}}};
            dden_in = mag_of(pivot_ff);
            drem_in = '0;
            dquo_in = '0;
            dcnt_in = QCW'(NW);
            st_in   = S_DIV;
         end

         S_DIV: begin
            if (dtrial >= {1'b0, dden_ff}) begin
               drem_in = EW'(dtrial - {1'b0, dden_ff});
               dquo_in = {dquo_ff[NW-2:0], 1'b1};
            end else begin
               drem_in = dtrial[EW-1:0];
               dquo_in = {dquo_ff[NW-2:0], 1'b0};
            end
            dnum_in = dnum_ff << 1;
            dcnt_in = dcnt_ff - QCW'(1);
            if (dcnt_ff == QCW'(1)) begin
               st_in = S_DIV_WR;
            end
         end

         S_DIV_WR: begin
            mult_in   = div_res;
            ram_we    = 1'b1;
            ram_waddr = addr_of(pi, ji);
            ram_wdata = div_res;
            c_in      = j_ff + CW'(1);
            st_in     = S_UPD_RDU;
         end

         // a[i][c] -= mult * a[j][c]
         S_UPD_RDU: begin
            ram_raddr = addr_of(pj, ci);
            st_in     = S_UPD_MUL;
         end

         S_UPD_MUL: begin
            prod_in   = $signed({{EW{mul_a[EW-1]}}, mul_a})
                      * $signed({{EW{ram_rdata[EW-1]}}, ram_rdata});
            ram_raddr = addr_of(pi, ci);
            st_in     = S_UPD_WR;
         end

         S_UPD_WR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_of(pi, ci);
            ram_wdata = sat_sub(ram_rdata, sat_prod(prod_ff));
            if (c_ff == n_m1) begin
               if (i_ff == n_m1) begin
                  j_in        = j_ff + CW'(1);
                  i_in        = j_ff + CW'(1);
                  best_in     = IW'(j_ff + CW'(1));
                  best_mag_in = '0;
                  st_in       = S_SRCH_RD;
               end else begin
                  i_in  = i_ff + CW'(1);
                  st_in = S_ELIM_RD;
               end
            end else begin
               c_in  = c_ff + CW'(1);
               st_in = S_UPD_RDU;
            end
         end

         // determinant over the U diagonal
         S_DET_RD: begin
            ram_raddr = addr_of(pi, ii);
            st_in     = S_DET_MUL;
         end

         S_DET_MUL: begin
            prod_in = $signed({{EW{mul_a[EW-1]}}, mul_a})
                    * $signed({{EW{ram_rdata[EW-1]}}, ram_rdata});
            st_in   = S_DET_ACC;
         end

         S_DET_ACC: begin
            det_in = sat_prod(prod_ff);
            if (i_ff == n_m1) begin
               st_in = S_DET_SIGN;
            end else begin
               i_in  = i_ff + CW'(1);
               st_in = S_DET_RD;
            end
         end

         S_DET_SIGN: begin
            if (parity_ff) begin
               det_in = (det_ff == EMIN) ? EMAX : (~det_ff + EW'(1));
            end
            i_in  = '0;
            c_in  = '0;
            st_in = S_OUT_RD;
         end

         // packed LU, row by row
         S_OUT_RD: begin
            ram_raddr = addr_of(pi, ci);
            st_in     = S_OUT_LD;
         end

         S_OUT_LD: begin
            o_valid_in = 1'b1;
            o_row_in   = ii;
            o_col_in   = ci;
            o_src_in   = pi;
            o_val_in   = ram_rdata;
            o_det_in   = out_last ? det_ff : '0;
            o_odd_in   = out_last ? parity_ff : 1'b0;
            o_degen_in = 1'b0;
            o_last_in  = out_last;
            st_in      = S_OUT_WAIT;
         end

         S_OUT_WAIT: begin
            if (rsp_tready) begin
               if (out_last) begin
                  st_in = S_LOAD;
               end else begin
                  if (c_ff == n_m1) begin
                     c_in = '0;
                     i_in = i_ff + CW'(1);
                  end else begin
                     c_in = c_ff + CW'(1);
                  end
                  st_in = S_OUT_RD;
               end
            end
         end

         default: begin
            st_in = S_LOAD;
         end
      endcase

      // register writes
      if (csr_valid) begin
         if (csr_index == REG_MATRIX_SIZE) begin
            size_in   = csr_data[SIZE_W-1:0];
            ld_row_in = '0;
            ld_col_in = '0;
         end else if (csr_index == REG_PIVOT_THRESHOLD) begin
            thr_in = csr_data[THR_W-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_LOAD;
         size_ff    <= SIZE_W'(4);
         thr_ff     <= THR_W'(1);
         ld_row_ff  <= '0;
         ld_col_ff  <= '0;
         parity_ff  <= 1'b0;
         o_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_SIZE; k++) begin
            perm_ff[k] <= IW'(k);
         end
      end else begin
         st_ff      <= st_in;
         size_ff    <= size_in;
         thr_ff     <= thr_in;
         ld_row_ff  <= ld_row_in;
         ld_col_ff  <= ld_col_in;
         parity_ff  <= parity_in;
         o_valid_ff <= o_valid_in;
         perm_ff    <= perm_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      i_ff        <= i_in;
      c_ff        <= c_in;
      best_ff     <= best_in;
      best_mag_ff <= best_mag_in;
      pivot_ff    <= pivot_in;
      mult_ff     <= mult_in;
      prod_ff     <= prod_in;
      det_ff      <= det_in;
      dnum_ff     <= dnum_in;
      dquo_ff     <= dquo_in;
      drem_ff     <= drem_in;
      dden_ff     <= dden_in;
      dcnt_ff     <= dcnt_in;
      dneg_ff     <= dneg_in;
      o_row_ff    <= o_row_in;
      o_col_ff    <= o_col_in;
      o_src_ff    <= o_src_in;
      o_val_ff    <= o_val_in;
      o_det_ff    <= o_det_in;
      o_odd_ff    <= o_odd_in;
      o_degen_ff  <= o_degen_in;
      o_last_ff   <= o_last_in;
   end

   // ---------------------------------------------------------------- ports
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = o_valid_ff;
   assign rsp_tdata    = RSP_W'({o_odd_ff, o_det_ff, o_src_ff, o_val_ff, o_col_ff, o_row_ff});
   assign rsp_tuser[0] = o_degen_ff;
   assign rsp_tlast    = o_last_ff;

endmodule

### design/lupd_ram.sv
module lupd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lup_decomposition_core_checker.sv
`include "lup_decomposition_core_defines.svh"

module lup_decomposition_core_checker #(
   parameter int MAX_SIZE      = 4,
   parameter int ELEMENT_WIDTH = 32
) (
   input logic                                       clock,
   input logic                                       reset,
   input logic                                       req_tready,
   input logic                                       rsp_tvalid,
   input logic                                       rsp_tready,
   input logic [((3*$clog2(MAX_SIZE)+2*ELEMENT_WIDTH+1+7)/8)*8-1:0] rsp_tdata,
   input logic [0:0]                                 rsp_tuser,
   input logic                                       rsp_tlast
);

   // nothing pending right after reset
   `LUPD_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_tvalid)
   // a degenerate word always closes the run
   `LUPD_ASSERT_IMPL(a_degen_last, clock, !reset && rsp_tvalid && rsp_tuser[0], rsp_tlast)
   // loading and draining share the matrix ram
   `LUPD_ASSERT_IMPL(a_no_load_in_drain, clock, !reset && rsp_tvalid, !req_tready)
   // stalled word holds
   `LUPD_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_tvalid && !rsp_tready, reset || (rsp_tvalid && $stable(rsp_tdata)))

endmodule

bind lup_decomposition_core lup_decomposition_core_checker #(
   .MAX_SIZE      (MAX_SIZE),
   .ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_checker (.*);

### tb/sv/tb_lup_decomposition_core.sv
`timescale 1ns / 1ps

module tb_lup_decomposition_core;
   import lupd_pkg::*;

   localparam int Q_ONE = 65536;
   localparam int STORE_DEPTH = 16;
   // an index past the register list, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 8'd9;
   localparam int SETTLE_CYCLES = 80;

   typedef enum logic {OP_ELEM, OP_CFG} op_kind_type;

   // one packed lu word as it leaves the block
   typedef struct packed {
      logic [1:0]  row;
      logic [1:0]  col;
      logic [31:0] lu;
      logic [1:0]  src;
      logic [31:0] det;
      logic        odd;
      logic        degen;
      logic        last;
   } lu_word_type;

   // one row of the directed plan, want is used only when typed is set
   typedef struct {
      op_kind_type op;
      logic [7:0]  idx;
      logic [31:0] val;
      bit          typed;
      lu_word_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;          // element_value

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // out_row, out_col, lu_value, source_row, determinant, odd_swaps
   logic [71:0] rsp_tdata;
   logic [0:0]  rsp_tuser;               // degenerate
   logic        rsp_tlast;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor copy of the block state
   int          elem_store[STORE_DEPTH];
   int          load_cnt = 0;
   logic [2:0]  size_reg = 3'd4;
   logic [15:0] thr_reg = 16'd1;

   lu_word_type lu_expect[$];
   int          err_cnt = 0;

   // idling knobs, percent of cycles
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   logic long_hold_req = 1'b0;

   lup_decomposition_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // fixed point helpers of the predictor
   // ---------------------------------------------------------------
   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // product rounded toward minus infinity
   function automatic longint fx_mul(longint a, longint b);
      longint p;
      p = a * b;
      if (p >= 0) return sat32(p / Q_ONE);
      return sat32(-(((-p) + (Q_ONE - 1)) / Q_ONE));
   endfunction

   function automatic longint fx_abs(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int size_used();
      if (size_reg < 1) return 1;
      if (size_reg > 4) return 4;
      return int'(size_reg);
   endfunction

   function automatic lu_word_type degen_word(int c);
      lu_word_type w;
      w = '0;
      w.row = c[1:0];
      w.col = c[1:0];
      w.degen = 1'b1;
      w.last = 1'b1;
      return w;
   endfunction

   // factor the loaded matrix, queue every lu word it produces
   function automatic void factor_matrix();
      int          n;
      longint      a[4][4];
      longint      tmp;
      int          perm[4];
      int          best;
      int          ptmp;
      bit          parity;
      longint      best_mag;
      longint      mult;
      longint      det;
      lu_word_type w;
      n = size_used();
      for (int i = 0; i < n; i++) begin
         perm[i] = i;
         for (int c = 0; c < n; c++) a[i][c] = elem_store[(i * n + c) % STORE_DEPTH];
      end
      parity = 1'b0;
      for (int j = 0; j < n; j++) begin
         best = j;
         best_mag = fx_abs(a[j][j]);
         // ties keep the earliest row
         for (int i = j + 1; i < n; i++)
            if (fx_abs(a[i][j]) > best_mag) begin
               best_mag = fx_abs(a[i][j]);
               best = i;
            end
         if (best_mag == 0 || best_mag < longint'(thr_reg)) begin
            lu_expect.push_back(degen_word(j));
            return;
         end
         if (best != j) begin
            for (int c = 0; c < n; c++) begin
               tmp = a[j][c];
               a[j][c] = a[best][c];
               a[best][c] = tmp;
            end
            ptmp = perm[j];
            perm[j] = perm[best];
            perm[best] = ptmp;
            parity = ~parity;
         end
         for (int i = j + 1; i < n; i++) begin
            mult = sat32((a[i][j] * Q_ONE) / a[j][j]);
            for (int c = j + 1; c < n; c++) a[i][c] = sat32(a[i][c] - fx_mul(mult, a[j][c]));
            a[i][j] = mult;
         end
      end
      det = Q_ONE;
      for (int i = 0; i < n; i++) det = fx_mul(det, a[i][i]);
      if (parity) det = sat32(-det);
      for (int i = 0; i < n; i++)
         for (int c = 0; c < n; c++) begin
            w = '0;
            w.row = i[1:0];
            w.col = c[1:0];
            w.lu = a[i][c][31:0];
            w.src = perm[i][1:0];
            if (i == n - 1 && c == n - 1) begin
               w.det = det[31:0];
               w.odd = parity;
               w.last = 1'b1;
            end
            lu_expect.push_back(w);
         end
   endfunction

   // element taken by the block, returns 1 when it closed a matrix
   function automatic bit take_element(logic [31:0] v);
      int n;
      n = size_used();
      elem_store[load_cnt % STORE_DEPTH] = $signed(v);
      load_cnt++;
      if (load_cnt < n * n) return 1'b0;
      load_cnt = 0;
      factor_matrix();
      return 1'b1;
   endfunction

   function automatic void take_config(logic [7:0] idx, logic [15:0] v);
      if (idx == REG_MATRIX_SIZE) begin
         size_reg = v[2:0];
         load_cnt = 0;
      end else if (idx == REG_PIVOT_THRESHOLD) begin
         thr_reg = v;
      end
   endfunction

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   // offers one word, honoring the sender idle rate
   task automatic send_word(input logic [31:0] v, output bit closed);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      closed = take_element(v);
   endtask

   // called only once the block is quiet and the sender is idle
   task automatic write_reg(input logic [7:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      take_config(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected word, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (lu_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver, long hold-off counted here
   int hold_cnt = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (long_hold_req && !hold_done) begin
         hold_cnt = 700;
         hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
         hold_cnt = hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // checker
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   always @(posedge clock) begin
      lu_word_type got;
      lu_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row = rsp_tdata[1:0];
         got.col = rsp_tdata[3:2];
         got.lu = rsp_tdata[35:4];
         got.src = rsp_tdata[37:36];
         got.det = rsp_tdata[69:38];
         got.odd = rsp_tdata[70];
         got.degen = rsp_tuser[0];
         got.last = rsp_tlast;
         if (lu_expect.size() == 0) begin
            report_mismatch("unexpected word", got.lu, 0);
         end else begin
            want = lu_expect.pop_front();
            if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
            if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
            if (got.lu !== want.lu) report_mismatch("lu_value", got.lu, want.lu);
            if (got.src !== want.src) report_mismatch("source_row", got.src, want.src);
            if (got.det !== want.det) report_mismatch("determinant", got.det, want.det);
            if (got.odd !== want.odd) report_mismatch("odd_swaps", got.odd, want.odd);
            if (got.degen !== want.degen) report_mismatch("degenerate", got.degen, want.degen);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   plan_row_type plan[$];

   function automatic void plan_elem(logic [31:0] v);
      plan.push_back('{OP_ELEM, 8'd0, v, 1'b0, '0});
   endfunction

   function automatic void plan_typed(logic [31:0] v, lu_word_type w);
      plan.push_back('{OP_ELEM, 8'd0, v, 1'b1, w});
   endfunction

   function automatic void plan_cfg(logic [7:0] idx, logic [31:0] v);
      plan.push_back('{OP_CFG, idx, v, 1'b0, '0});
   endfunction

   // random element, mostly modest values so pivots pass, some raw 32-bit noise
   function automatic logic [31:0] rand_elem();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 32'h0;
      if (pick < 25) return $urandom();
      if (pick < 30) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
   endfunction

   initial begin
      bit          closed;
      int          sent;
      lu_word_type w;
      logic [2:0]  sizes[4];
      logic [15:0] thrs[4];
      int          idles[4];
      int          stalls[4];

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one by one matrix, zero pivot
      plan_cfg(REG_MATRIX_SIZE, 32'd1);
      plan_typed(32'h0, degen_word(0));
      // one by one, value 1.0
      w = '0;
      w.lu = 32'h0001_0000;
      w.det = 32'h0001_0000;
      w.last = 1'b1;
      plan_typed(32'h0001_0000, w);
      // most negative element, determinant follows it
      w.lu = 32'h8000_0000;
      w.det = 32'h8000_0000;
      plan_typed(32'h8000_0000, w);
      // zero pivot is degenerate even with a zero threshold
      plan_cfg(REG_PIVOT_THRESHOLD, 32'd0);
      plan_typed(32'h0, degen_word(0));
      // largest threshold rejects a pivot just under it
      plan_cfg(REG_PIVOT_THRESHOLD, 32'h0000_FFFF);
      plan_typed(32'h0000_FFFE, degen_word(0));
      plan_cfg(REG_PIVOT_THRESHOLD, 32'd1);
      // size zero acts as one
      plan_cfg(REG_MATRIX_SIZE, 32'd0);
      plan_elem(32'h7FFF_FFFF);
      // pivot tie between rows of equal magnitude
      plan_cfg(REG_MATRIX_SIZE, 32'd2);
      plan_elem(32'hFFFF_0000);
      plan_elem(32'h0002_0000);
      plan_elem(32'h0001_0000);
      plan_elem(32'h0003_0000);
      // partial load cut short by a size write
      plan_elem(32'h1234_5678);
      plan_elem(32'h8765_4321);
      plan_cfg(REG_MATRIX_SIZE, 32'd1);
      plan_elem(32'hFFFF_FFFF);
      // write to no register
      plan_cfg(REG_UNUSED, 32'h0000_0003);
      plan_elem(32'h0000_0001);

      foreach (plan[k]) begin
         if (plan[k].op == OP_CFG) begin
            settle();
            write_reg(plan[k].idx, plan[k].val[15:0]);
         end else begin
            send_word(plan[k].val, closed);
            if (plan[k].typed && closed) begin
               void'(lu_expect.pop_back());
               lu_expect.push_back(plan[k].want);
            end
         end
      end

      // random phases, each with its own size, threshold and idling
      sizes = '{3'd4, 3'd1, 3'd3, 3'd7};
      thrs = '{16'd0, 16'hFFFF, 16'd1, 16'd300};
      idles = '{0, 63, 0, 37};
      stalls = '{0, 0, 63, 37};
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         write_reg(REG_MATRIX_SIZE, {13'h0, sizes[ph]});
         write_reg(REG_PIVOT_THRESHOLD, thrs[ph]);
         if (ph == 2) write_reg(REG_UNUSED, 16'($urandom()));
         send_idle_pct = idles[ph];
         rsp_stall_pct = stalls[ph];
         // receiver holds off for a long while as the sender keeps offering
         if (ph == 0) long_hold_req <= 1'b1;
         sent = 0;
         closed = 1'b0;
         while (sent < 30 || !closed) begin
            send_word(rand_elem(), closed);
            sent++;
         end
      end
      settle();
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/lupd_pkg.sv
design/lupd_ram.sv
design/lup_decomposition_core.sv
design/lup_decomposition_core_checker.sv
tb/sv/tb_lup_decomposition_core.sv
